@@ rtl/wtne_pkg.sv @@
package wtne_pkg;

    // widths of the time fields
    localparam int unsigned HR_W    = 5;
    localparam int unsigned MN_W    = 6;
    localparam int unsigned WD_W    = 3;
    localparam int unsigned DAYS_W  = 7;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned SEC_W   = 32;
    localparam int unsigned TOD_W   = 12;   // minute of day, up to 31*60+63
    localparam int unsigned DELTA_W = 16;   // signed minutes to an event
    localparam int unsigned KDAY_W  = 3;    // day offset 0..7
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [DELTA_W-1:0] DAY_MINUTES  = DELTA_W'(1440);
    localparam logic [WD_W-1:0]    DAYS_IN_WEEK = WD_W'(7);
    localparam logic [KDAY_W-1:0]  NO_DAY       = KDAY_W'(7);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONCE_ENABLE = 3'd0,
        CFG_ONCE_ACTION = 3'd1,
        CFG_ONCE_HOUR   = 3'd2,
        CFG_ONCE_MINUTE = 3'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ONCE,
        ST_SLOT,
        ST_SCALE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [SLOT_W-1:0] slot_id;
        logic [DAYS_W-1:0] week_mask;
        logic              slot_action;
        logic [HR_W-1:0]   slot_hour;
        logic [MN_W-1:0]   slot_minute;
        logic [WD_W-1:0]   now_weekday;
        logic [HR_W-1:0]   now_hour;
        logic [MN_W-1:0]   now_minute;
        logic [SEC_W-1:0]  now_seconds;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [SEC_W-1:0] next_stamp;
        logic             next_action;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_item;

    // one stored weekly timer
    typedef struct packed {
        logic              valid;
        logic [DAYS_W-1:0] days;
        logic              act;
        logic [HR_W-1:0]   hr;
        logic [MN_W-1:0]   mn;
    } t_slot;

    // operands handed to the shared delta unit
    typedef struct packed {
        logic              is_once;
        logic [DAYS_W-1:0] days;
        logic [HR_W-1:0]   hr;
        logic [MN_W-1:0]   mn;
    } t_delta_req;

    // the query time held for the whole search
    typedef struct packed {
        logic [WD_W-1:0]  wd;
        logic [HR_W-1:0]  hr;
        logic [MN_W-1:0]  mn;
        logic [TOD_W-1:0] tod;
    } t_now;

    // hour*60 + minute by shift and subtract
    function automatic logic [TOD_W-1:0] hm_to_min(input logic [HR_W-1:0] hr,
                                                   input logic [MN_W-1:0] mn);
        logic [TOD_W-1:0] h;
        h = TOD_W'(hr);
        return (h << 6) - (h << 2) + TOD_W'(mn);
    endfunction

endpackage

@@ rtl/wtne_if.sv @@
interface wtne_in_if import wtne_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wtne_out_if import wtne_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wtne_cfg_if import wtne_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/wtne_slot_table.sv @@
module wtne_slot_table
    import wtne_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 6,
    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_slot            i_wr_entry,
    input  logic             i_clr_en,
    input  logic [IDX_W-1:0] i_clr_idx,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_slot            o_rd_entry
);

    logic [NUM_SLOTS-1:0] r_valid;
    t_slot                r_store [NUM_SLOTS];
    t_slot                r_rd;
    t_slot                w_rd_sel;

    // valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= i_wr_entry.valid;
            end
            if (i_clr_en) begin
                r_valid[i_clr_idx] <= 1'b0;
            end
        end
    end

    // timer payload
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_store[i_wr_idx] <= i_wr_entry;
        end
    end

    // entry at the read address with its live valid flag
    always_comb begin
        w_rd_sel       = r_store[i_rd_idx];
        w_rd_sel.valid = r_valid[i_rd_idx];
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= w_rd_sel;
        end
    end

    assign o_rd_entry = r_rd;

endmodule

@@ rtl/wtne_delta_unit.sv @@
module wtne_delta_unit
    import wtne_pkg::*;
(
    input  t_delta_req                 i_req,
    input  t_now                       i_now,
    output logic signed [DELTA_W-1:0]  o_delta
);

    logic [TOD_W-1:0]          w_tod;
    logic signed [DELTA_W-1:0] w_diff;
    logic signed [DELTA_W-1:0] w_once;
    logic signed [DELTA_W-1:0] w_week;
    logic                      w_passed;
    logic [DAYS_W-1:0]         w_rot;
    logic [WD_W:0]             w_pos [DAYS_W];
    logic [KDAY_W-1:0]         w_k;
    logic [DELTA_W-1:0]        w_kday;

    // minutes from now to the timer's time of day
    assign w_tod  = hm_to_min(i_req.hr, i_req.mn);
    assign w_diff = $signed(DELTA_W'(w_tod)) - $signed(DELTA_W'(i_now.tod));

    // daily timer wraps into the next day
    assign w_once = (w_diff < 0) ? w_diff + $signed(DAY_MINUTES) : w_diff;

    assign w_passed = (i_req.hr < i_now.hr) ||
                      ((i_req.hr == i_now.hr) && (i_req.mn < i_now.mn));

    // weekday mask rotated so bit 0 is today
    always_comb begin
        for (int off = 0; off < DAYS_W; off++) begin
            w_pos[off] = {1'b0, i_now.wd} + (WD_W+1)'(off);
            if (w_pos[off] >= {1'b0, DAYS_IN_WEEK}) begin
                w_pos[off] = w_pos[off] - {1'b0, DAYS_IN_WEEK};
            end
            w_rot[off] = i_req.days[w_pos[off][WD_W-1:0]];
        end
        w_rot[0] = w_rot[0] & ~w_passed;
    end

    // first day offset with the timer due
    always_comb begin
        w_k = NO_DAY;
        for (int off = DAYS_W - 1; off >= 0; off--) begin
            if (w_rot[off]) begin
                w_k = KDAY_W'(off);
            end
        end
    end

    assign w_kday  = DELTA_W'(w_k) * DAY_MINUTES;
    assign w_week  = $signed(w_kday) + w_diff;
    assign o_delta = i_req.is_once ? w_once : w_week;

endmodule

@@ rtl/weekly_timer_next_event.sv @@
// channel  | dir | handshake        | payload
// ---------+-----+------------------+-----------------------------------------
// i_in     | in  | valid / ready    | cmd, slot write fields, query time
// o_res    | out | valid / ready    | found, next_stamp, next_action
// i_cfg    | in  | valid / ready    | idx (register number), wdata
//
// a slot write is taken when the item is accepted; a query holds the input through
// its steps: the daily timer, each slot in turn through the shared delta unit and
// compare, then scaling minutes to seconds and loading the result
// reset (synchronous, active low) clears the slot valid flags, the registers
// and the held action; no clearing pass is needed
// a stalled result holds the search in its last cycle until o_res is free;
// the config channel is always ready
module weekly_timer_next_event
    import wtne_pkg::*;
#(
    parameter int unsigned NUM_SLOTS = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtne_in_if.sink     i_in,
    wtne_out_if.source  o_res,
    wtne_cfg_if.sink    i_cfg
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // config registers
    logic              r_once_enable;
    logic              r_once_action;
    logic [HR_W-1:0]   r_once_hour;
    logic [MN_W-1:0]   r_once_minute;

    // sequencer and search state
    t_state                    r_state, n_state;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic                      r_have, n_have;
    logic signed [DELTA_W-1:0] r_best, n_best;
    logic                      r_act, n_act;
    logic                      r_held, n_held;
    logic [SEC_W-1:0]          r_prod;
    t_now                      r_now;
    logic [SEC_W-1:0]          r_sec;
    logic                      r_out_valid, n_out_valid;
    t_out_item                 r_out, n_out;

    logic                      w_in_acc;
    logic                      w_wr_en;
    logic [4:0]                w_id_m1;
    t_slot                     w_wr_entry;
    logic                      w_clr_en;
    logic                      w_rd_en;
    logic [IDX_W-1:0]          w_rd_idx;
    t_slot                     w_entry;
    t_delta_req                w_req;
    logic signed [DELTA_W-1:0] w_delta;
    logic [SEC_W-1:0]          w_best_ext;
    logic                      w_last;
    logic                      w_out_free;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_last      = (r_idx == LAST_IDX);
    assign w_out_free  = !r_out_valid || o_res.ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_once_enable <= 1'b0;
            r_once_action <= 1'b0;
            r_once_hour   <= '0;
            r_once_minute <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.data.idx)
                CFG_ONCE_ENABLE: r_once_enable <= i_cfg.data.wdata[0];
                CFG_ONCE_ACTION: r_once_action <= i_cfg.data.wdata[0];
                CFG_ONCE_HOUR:   r_once_hour   <= i_cfg.data.wdata[HR_W-1:0];
                CFG_ONCE_MINUTE: r_once_minute <= i_cfg.data.wdata[MN_W-1:0];
                default: ;
            endcase
        end
    end

    // slot write decode, one-based id
    assign w_id_m1 = {2'b00, i_in.data.slot_id} - 5'd1;
    assign w_wr_en = w_in_acc && (i_in.data.cmd == CMD_WRITE) &&
                     (i_in.data.slot_id != '0) &&
                     ({2'b00, i_in.data.slot_id} <= 5'(NUM_SLOTS));

    always_comb begin
        w_wr_entry.valid = (i_in.data.week_mask != '0);
        w_wr_entry.days  = i_in.data.week_mask;
        w_wr_entry.act   = i_in.data.slot_action;
        w_wr_entry.hr    = i_in.data.slot_hour;
        w_wr_entry.mn    = i_in.data.slot_minute;
    end

    // slot reads run one ahead of the compare
    assign w_rd_en  = (r_state == ST_ONCE) || ((r_state == ST_SLOT) && !w_last);
    assign w_rd_idx = (r_state == ST_ONCE) ? r_idx : r_idx + IDX_W'(1);

    // a valid entry with no days left drops out
    assign w_clr_en = (r_state == ST_SLOT) && w_entry.valid && (w_entry.days == '0);

    wtne_slot_table #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (IDX_W'(w_id_m1)),
        .i_wr_entry (w_wr_entry),
        .i_clr_en   (w_clr_en),
        .i_clr_idx  (r_idx),
        .i_rd_en    (w_rd_en),
        .i_rd_idx   (w_rd_idx),
        .o_rd_entry (w_entry)
    );

    // operands for the shared delta unit
    always_comb begin
        if (r_state == ST_ONCE) begin
            w_req.is_once = 1'b1;
            w_req.days    = '0;
            w_req.hr      = r_once_hour;
            w_req.mn      = r_once_minute;
        end else begin
            w_req.is_once = 1'b0;
            w_req.days    = w_entry.days;
            w_req.hr      = w_entry.hr;
            w_req.mn      = w_entry.mn;
        end
    end

    wtne_delta_unit u_delta (
        .i_req   (w_req),
        .i_now   (r_now),
        .o_delta (w_delta)
    );

    assign w_best_ext = {{(SEC_W-DELTA_W){r_best[DELTA_W-1]}}, r_best};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_have      = r_have;
        n_best      = r_best;
        n_act       = r_act;
        n_held      = r_held;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_in.data.cmd == CMD_QUERY)) begin
                    n_idx   = '0;
                    n_state = ST_ONCE;
                end
            end
            ST_ONCE: begin
                n_have  = r_once_enable;
                n_best  = w_delta;
                n_act   = r_once_action;
                n_state = ST_SLOT;
            end
            ST_SLOT: begin
                if (w_entry.valid && (w_entry.days != '0) &&
                    (!r_have || (w_delta < r_best))) begin
                    n_have = 1'b1;
                    n_best = w_delta;
                    n_act  = w_entry.act;
                end
                if (w_last) begin
                    n_state = ST_SCALE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_SCALE: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out.found = r_have;
                    if (r_have) begin
                        n_out.next_stamp  = r_sec + r_prod;
                        n_out.next_action = r_act;
                        n_held            = r_act;
                    end else begin
                        n_out.next_stamp  = '0;
                        n_out.next_action = r_held;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_have      <= 1'b0;
            r_held      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_have      <= n_have;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // search payload
    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        r_act  <= n_act;
        r_out  <= n_out;
        r_prod <= (w_best_ext << 6) - (w_best_ext << 2);
        if (w_in_acc) begin
            r_now.wd  <= (i_in.data.now_weekday >= DAYS_IN_WEEK) ? '0
                                                                 : i_in.data.now_weekday;
            r_now.hr  <= i_in.data.now_hour;
            r_now.mn  <= i_in.data.now_minute;
            r_now.tod <= hm_to_min(i_in.data.now_hour, i_in.data.now_minute);
            r_sec     <= i_in.data.now_seconds;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

@@ sim/tb_weekly_timer_next_event.sv @@
`timescale 1ns / 1ps

import wtne_pkg::*;

// expected-event tracker: keeps its own copy of the timer table and the
// once timer, and queues the event each accepted query should return
class next_event_scoreboard;
    localparam int TIMER_SLOTS = 6;

    bit        once_en;
    bit        once_act;
    bit [4:0]  once_hr;
    bit [5:0]  once_mn;
    bit        tbl_valid [TIMER_SLOTS];
    bit [6:0]  tbl_days  [TIMER_SLOTS];
    bit        tbl_act   [TIMER_SLOTS];
    bit [4:0]  tbl_hr    [TIMER_SLOTS];
    bit [5:0]  tbl_mn    [TIMER_SLOTS];
    bit        last_act;
    t_out_item expected_events [$];
    int        errors;

    function new();
        once_en  = 1'b0;
        once_act = 1'b0;
        once_hr  = '0;
        once_mn  = '0;
        last_act = 1'b0;
        errors   = 0;
        foreach (tbl_valid[s]) begin
            tbl_valid[s] = 1'b0;
            tbl_days[s]  = '0;
            tbl_act[s]   = 1'b0;
            tbl_hr[s]    = '0;
            tbl_mn[s]    = '0;
        end
    endfunction

    // register write accepted on the config channel
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] wdata);
        case (t_cfg_idx'(idx))
            CFG_ONCE_ENABLE: once_en  = wdata[0];
            CFG_ONCE_ACTION: once_act = wdata[0];
            CFG_ONCE_HOUR:   once_hr  = wdata[4:0];
            CFG_ONCE_MINUTE: once_mn  = wdata[5:0];
            default: ;
        endcase
    endfunction

    // minutes from now to the next firing of one weekly slot
    function int slot_minutes(int s, int wd, int now_min, bit [4:0] nh, bit [5:0] nm);
        bit passed;
        int k;
        int day;
        passed = (tbl_hr[s] < nh) || (tbl_hr[s] == nh && tbl_mn[s] < nm);
        k = 7;
        for (int off = 0; off < 7; off++) begin
            day = (wd + off) % 7;
            if (tbl_days[s][day] && !(off == 0 && passed)) begin
                k = off;
                break;
            end
        end
        return k * 1440 + int'(tbl_hr[s]) * 60 + int'(tbl_mn[s]) - now_min;
    endfunction

    // accepted input item: update the table or queue the next event
    function void note_item(t_in_item it);
        int        sid;
        int        wd;
        int        now_min;
        int        best;
        int        d;
        bit        have;
        bit        act;
        t_out_item ev;
        if (it.cmd == CMD_WRITE) begin
            sid = int'(it.slot_id);
            if (sid >= 1 && sid <= TIMER_SLOTS) begin
                tbl_valid[sid-1] = (it.week_mask != '0);
                tbl_days[sid-1]  = it.week_mask;
                tbl_act[sid-1]   = it.slot_action;
                tbl_hr[sid-1]    = it.slot_hour;
                tbl_mn[sid-1]    = it.slot_minute;
            end
            return;
        end
        wd = int'(it.now_weekday);
        if (wd >= 7)
            wd = 0;
        now_min = int'(it.now_hour) * 60 + int'(it.now_minute);
        have = 1'b0;
        best = 0;
        act  = 1'b0;
        if (once_en) begin
            best = int'(once_hr) * 60 + int'(once_mn) - now_min;
            if (best < 0)
                best += 1440;
            act  = once_act;
            have = 1'b1;
        end
        for (int s = 0; s < TIMER_SLOTS; s++) begin
            if (!tbl_valid[s])
                continue;
            if (tbl_days[s] == '0) begin
                tbl_valid[s] = 1'b0;
                continue;
            end
            d = slot_minutes(s, wd, now_min, it.now_hour, it.now_minute);
            if (!have || d < best) begin
                best = d;
                act  = tbl_act[s];
                have = 1'b1;
            end
        end
        if (have) begin
            last_act       = act;
            ev.found       = 1'b1;
            ev.next_stamp  = it.now_seconds + 32'(best * 60);
            ev.next_action = act;
        end else begin
            ev.found       = 1'b0;
            ev.next_stamp  = '0;
            ev.next_action = last_act;
        end
        expected_events.push_back(ev);
    endfunction

    // result accepted on the output channel
    function void check_event(t_out_item got);
        t_out_item want;
        if (expected_events.size() == 0) begin
            $display("%0t: result with nothing expected, found=%0d stamp=%h action=%0d",
                     $time, got.found, got.next_stamp, got.next_action);
            errors++;
            return;
        end
        want = expected_events.pop_front();
        if (got.found !== want.found) begin
            $display("%0t: found expected %0d got %0d", $time, want.found, got.found);
            errors++;
        end
        if (got.next_stamp !== want.next_stamp) begin
            $display("%0t: next_stamp expected %h got %h",
                     $time, want.next_stamp, got.next_stamp);
            errors++;
        end
        if (got.next_action !== want.next_action) begin
            $display("%0t: next_action expected %0d got %0d",
                     $time, want.next_action, got.next_action);
            errors++;
        end
    endfunction

    function int pending();
        return expected_events.size();
    endfunction
endclass

module tb_weekly_timer_next_event;

    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 170;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   in_idle_pct = 0;
    int   out_stall_pct = 0;

    next_event_scoreboard sb;

    wtne_in_if  in_if ();
    wtne_out_if res_if ();
    wtne_cfg_if cfg_if ();

    weekly_timer_next_event #(
        .NUM_SLOTS(6)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result back-pressure
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_event(res_if.data);
    end

    // random field values, mostly in range with occasional out-of-range ones
    function automatic logic [HR_W-1:0] pick_hour();
        return ($urandom_range(15) == 0) ? HR_W'($urandom) : HR_W'($urandom_range(23));
    endfunction

    function automatic logic [MN_W-1:0] pick_minute();
        return ($urandom_range(15) == 0) ? MN_W'($urandom) : MN_W'($urandom_range(59));
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        it.cmd         = ($urandom_range(99) < 40) ? CMD_WRITE : CMD_QUERY;
        it.slot_id     = ($urandom_range(9) == 0) ? SLOT_W'($urandom) :
                                                    SLOT_W'($urandom_range(6, 1));
        case ($urandom_range(9))
            0:       it.week_mask = '0;
            1:       it.week_mask = 7'h7f;
            2:       it.week_mask = DAYS_W'(1 << $urandom_range(6));
            default: it.week_mask = DAYS_W'($urandom);
        endcase
        it.slot_action = 1'($urandom);
        it.slot_hour   = pick_hour();
        it.slot_minute = pick_minute();
        it.now_weekday = ($urandom_range(15) == 0) ? WD_W'(7) : WD_W'($urandom_range(6));
        it.now_hour    = pick_hour();
        it.now_minute  = pick_minute();
        case ($urandom_range(7))
            0:       it.now_seconds = 32'hffff_ffff - 32'($urandom_range(200000));
            1:       it.now_seconds = 32'($urandom_range(200000));
            default: it.now_seconds = $urandom;
        endcase
        return it;
    endfunction

    function automatic t_in_item slot_write(int id, int mask, bit act, int hr, int mn);
        t_in_item it;
        it             = random_item();
        it.cmd         = CMD_WRITE;
        it.slot_id     = SLOT_W'(id);
        it.week_mask   = DAYS_W'(mask);
        it.slot_action = act;
        it.slot_hour   = HR_W'(hr);
        it.slot_minute = MN_W'(mn);
        return it;
    endfunction

    function automatic t_in_item next_query(int wd, int hr, int mn, logic [31:0] secs);
        t_in_item it;
        it             = random_item();
        it.cmd         = CMD_QUERY;
        it.now_weekday = WD_W'(wd);
        it.now_hour    = HR_W'(hr);
        it.now_minute  = MN_W'(mn);
        it.now_seconds = secs;
        return it;
    endfunction

    // present one item, with random idle cycles ahead of it; valid stays up
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do
            @(posedge i_clk);
        while (!in_if.ready);
        sb.note_item(it);
    endtask

    // stop sending and let every expected event come back
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // load all four once-timer registers, junk in the unused data bits
    task automatic write_once_timer(input bit en, input bit act,
                                    input logic [HR_W-1:0] hr, input logic [MN_W-1:0] mn);
        t_cfg_item regs [4];
        regs[0].idx   = CFG_ONCE_ENABLE;
        regs[0].wdata = {7'($urandom), en};
        regs[1].idx   = CFG_ONCE_ACTION;
        regs[1].wdata = {7'($urandom), act};
        regs[2].idx   = CFG_ONCE_HOUR;
        regs[2].wdata = {3'($urandom), hr};
        regs[3].idx   = CFG_ONCE_MINUTE;
        regs[3].wdata = {2'($urandom), mn};
        foreach (regs[i]) begin
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= regs[i];
            do
                @(posedge i_clk);
            while (!cfg_if.ready);
            sb.set_register(regs[i].idx, regs[i].wdata);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: once timer off after reset
        send_item(next_query(3, 12, 0, 32'd0));                 // nothing found
        send_item(slot_write(0, 7'h7f, 1'b1, 8, 0));             // slot zero ignored
        send_item(slot_write(7, 7'h7f, 1'b1, 8, 0));             // beyond table ignored
        send_item(next_query(3, 12, 0, 32'd500));
        send_item(slot_write(2, 7'h7f, 1'b1, 12, 0));
        send_item(next_query(7, 12, 0, 32'hffff_ffff));          // weekday seven, event now
        send_item(next_query(0, 12, 1, 32'd1000));               // slot time just past
        send_item(slot_write(1, 7'h01, 1'b0, 31, 63));           // largest hour and minute
        send_item(next_query(6, 23, 59, $urandom));
        send_item(slot_write(3, 7'h00, 1'b1, 5, 5));             // empty mask, stored invalid
        send_item(next_query(3, 5, 5, $urandom));
        send_item(slot_write(6, 7'h40, 1'b0, 12, 0));
        send_item(next_query(6, 11, 0, $urandom));               // tie, lower slot wins
        send_item(slot_write(4, 7'h7f, 1'b0, 11, 0));
        send_item(next_query(2, 10, 63, 32'd10));                // negative delta wraps
        wait_drain();

        // directed: once timer on
        write_once_timer(1'b1, 1'b0, 5'd12, 6'd0);
        send_item(next_query(6, 11, 30, $urandom));              // tie, once timer wins
        send_item(next_query(1, 31, 63, $urandom));              // now past end of day
        send_item(slot_write(1, 7'h00, 1'b0, 0, 0));
        send_item(slot_write(2, 7'h00, 1'b0, 0, 0));
        send_item(slot_write(4, 7'h00, 1'b1, 0, 0));
        send_item(slot_write(6, 7'h00, 1'b1, 0, 0));
        send_item(next_query(0, 0, 0, 32'd0));                   // once timer alone
        wait_drain();
        write_once_timer(1'b0, 1'b1, 5'd0, 6'd0);
        send_item(next_query(4, 23, 59, $urandom));              // nothing found, action held
        wait_drain();

        // random phases, each loading the once timer and using one of four idle and stall patterns
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: write_once_timer(1'b1, 1'b1, 5'd0, 6'd0);
                1: write_once_timer(1'b1, 1'b0, 5'd23, 6'd59);
                2: write_once_timer(1'b0, 1'b1, 5'd12, 6'd30);
                3: write_once_timer(1'b1, 1'b1, 5'd31, 6'd63);
                5: write_once_timer(1'b0, 1'b0, 5'd0, 6'd0);
                6: write_once_timer(1'b1, 1'b0, pick_hour(), pick_minute());
                default: write_once_timer(1'b1, 1'($urandom), HR_W'($urandom_range(23)),
                                          MN_W'($urandom_range(59)));
            endcase
            case (p % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 68; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 68; end
                default: begin in_idle_pct = 31; out_stall_pct = 31; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off mid-phase until the block is empty
                if (n == PHASE_ITEMS / 2)
                    wait_drain();
                send_item(random_item());
            end
            wait_drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
